>>> sv/r2h_pkg.sv
package r2h_pkg;

  // channel and hue scaling
  localparam int CHANNEL_BITS  = 8;
  localparam int HUE_FRAC_BITS = 6;

  localparam int CH_MAX     = (1 << CHANNEL_BITS) - 1;
  localparam int HUE_SECTOR = 60 << HUE_FRAC_BITS;
  localparam int HUE_FULL   = 360 << HUE_FRAC_BITS;

  // output hue width, quotient widths and divider depth
  localparam int HUE_W  = $clog2(HUE_FULL);
  localparam int HUE_QW = $clog2(HUE_SECTOR + 1);
  localparam int NDIV   = (HUE_QW > CHANNEL_BITS) ? HUE_QW : CHANNEL_BITS;
  localparam int NUM_W  = CHANNEL_BITS + NDIV;
  localparam int HS_W   = HUE_W + 2;

  // sector codes: which channel holds the maximum
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef struct packed {
    chan_t      mx;
    logic       neg;
    logic [1:0] sector;
    logic       defined;
    logic       grey;
  } side_t;

  // first stage result
  typedef struct packed {
    chan_t      delta;
    chan_t      abs_diff;
    side_t      side;
  } front_t;

  // one step of the dual restoring divider
  typedef struct packed {
    logic [NUM_W-1:0] sat_rem;
    chan_t            sat_den;
    logic [NDIV-1:0]  sat_q;
    logic [NUM_W-1:0] hue_rem;
    chan_t            hue_den;
    logic [NDIV-1:0]  hue_q;
    side_t            side;
  } div_st_t;

endpackage

>>> sv/r2h_pix_if.sv
interface r2h_pix_if;
  logic                 valid;
  logic                 ready;
  r2h_pkg::chan_t       red;
  r2h_pkg::chan_t       green;
  r2h_pkg::chan_t       blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> sv/r2h_hsv_if.sv
interface r2h_hsv_if;
  logic                       valid;
  logic                       ready;
  logic [r2h_pkg::HUE_W-1:0]  hue;
  logic                       hue_defined;
  r2h_pkg::chan_t             saturation;
  r2h_pkg::chan_t             brightness;

  modport source (output valid, output hue, output hue_defined, output saturation,
                  output brightness, input ready);
  modport sink   (input valid, input hue, input hue_defined, input saturation,
                  input brightness, output ready);
endinterface

>>> sv/r2h_div_pipe.sv
// Two restoring dividers side by side, one quotient bit of each per stage.
// A full stage holds while the next one cannot move; an empty stage always loads.
module r2h_div_pipe (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  r2h_pkg::div_st_t in_st,
  output logic             out_valid,
  input  logic             out_ready,
  output r2h_pkg::div_st_t out_st
);

  localparam int N = r2h_pkg::NDIV;

  logic [N-1:0]     v_r;
  logic [N-1:0]     v_nxt;
  logic [N-1:0]     rdy;
  r2h_pkg::div_st_t st_r   [N];
  r2h_pkg::div_st_t st_nxt [N];

  always_comb begin
    rdy[N-1] = !v_r[N-1] || out_ready;
    for (int j = N - 2; j >= 0; j--) begin
      rdy[j] = !v_r[j] || rdy[j+1];
    end
  end

  always_comb begin
    r2h_pkg::div_st_t        src;
    logic [r2h_pkg::NUM_W-1:0] sat_sh;
    logic [r2h_pkg::NUM_W-1:0] hue_sh;
    for (int j = 0; j < N; j++) begin
      if (j == 0) begin
        src      = in_st;
        v_nxt[j] = in_valid;
      end else begin
        src      = st_r[j-1];
        v_nxt[j] = v_r[j-1];
      end
      sat_sh = r2h_pkg::NUM_W'(src.sat_den) << (N - 1 - j);
      hue_sh = r2h_pkg::NUM_W'(src.hue_den) << (N - 1 - j);
      st_nxt[j] = src;
      if (src.sat_rem >= sat_sh) begin
        st_nxt[j].sat_rem        = src.sat_rem - sat_sh;
        st_nxt[j].sat_q[N-1-j]   = 1'b1;
      end
      if (src.hue_rem >= hue_sh) begin
        st_nxt[j].hue_rem        = src.hue_rem - hue_sh;
        st_nxt[j].hue_q[N-1-j]   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int j = 0; j < N; j++) begin
        if (rdy[j]) begin
          v_r[j] <= v_nxt[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < N; j++) begin
      if (rdy[j]) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];
  assign out_st    = st_r[N-1];

endmodule

>>> sv/rgb_to_hsv_converter_top.sv
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    red, green, blue (8 bits each)
// out_ch    out  valid/ready    hue (15), hue_defined (1), saturation (8), brightness (8)
//
// One request per clock sustained while out_ch is not stalled. The stages are: one
// for max/min, one for the constant products, one per quotient bit of the hue
// divider, one for the sector offset and wrap.
// Reset (rst_n low at a clock edge) empties every stage; payload is not cleared.
// A stall on out_ch holds only the full stages behind it; empty stages keep
// loading, so bubbles are squeezed out and nothing is dropped or repeated.
module rgb_to_hsv_converter_top (
  input  logic       clk,
  input  logic       rst_n,
  r2h_pix_if.sink    in_ch,
  r2h_hsv_if.source  out_ch
);

  localparam int CB   = r2h_pkg::CHANNEL_BITS;
  localparam int HS_W = r2h_pkg::HS_W;

  // ---------------------------------------------------------------- stage A
  // max, min, winning sector and the signed difference of the other two
  logic             va_r, va_nxt;
  r2h_pkg::front_t  a_r, a_nxt;
  logic             rdy_a;

  // ---------------------------------------------------------------- stage B
  // dividends: delta*CH_MAX for saturation, SECTOR*|diff| for hue
  logic             vb_r, vb_nxt;
  r2h_pkg::div_st_t b_r, b_nxt;
  logic             rdy_b;

  // divider handshake
  logic             div_in_ready;
  logic             div_out_valid;
  r2h_pkg::div_st_t div_out;

  // ---------------------------------------------------------------- stage F
  logic             vf_r, vf_nxt;
  logic             rdy_f;
  logic [r2h_pkg::HUE_W-1:0] hue_r, hue_nxt;
  logic             def_r, def_nxt;
  r2h_pkg::chan_t   sat_r, sat_nxt;
  r2h_pkg::chan_t   val_r, val_nxt;

  // ready runs back from the output: a stage moves if it is empty or its
  // successor moves
  assign rdy_f = !vf_r || out_ch.ready;
  assign rdy_b = !vb_r || div_in_ready;
  assign rdy_a = !va_r || rdy_b;
  assign in_ch.ready = rdy_a;

  // stage A logic
  always_comb begin
    r2h_pkg::chan_t    r, g, b, mx, mn;
    logic signed [CB:0] diff;
    r = in_ch.red;
    g = in_ch.green;
    b = in_ch.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    // red wins ties, then green
    if (r == mx) begin
      a_nxt.side.sector = r2h_pkg::SEC_RED;
      diff = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (g == mx) begin
      a_nxt.side.sector = r2h_pkg::SEC_GREEN;
      diff = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      a_nxt.side.sector = r2h_pkg::SEC_BLUE;
      diff = $signed({1'b0, r}) - $signed({1'b0, g});
    end
    a_nxt.side.neg     = diff[CB];
    a_nxt.abs_diff     = diff[CB] ? CB'(-diff) : diff[CB-1:0];
    a_nxt.delta        = mx - mn;
    a_nxt.side.mx      = mx;
    a_nxt.side.defined = (mx != '0);
    a_nxt.side.grey    = (mx == mn);
    va_nxt = in_ch.valid;
  end

  // stage B logic: constant multiplies only
  always_comb begin
    b_nxt.sat_rem = r2h_pkg::NUM_W'(a_r.delta) * r2h_pkg::NUM_W'(r2h_pkg::CH_MAX);
    b_nxt.sat_den = a_r.side.mx;
    b_nxt.sat_q   = '0;
    b_nxt.hue_rem = r2h_pkg::NUM_W'(a_r.abs_diff) * r2h_pkg::NUM_W'(r2h_pkg::HUE_SECTOR);
    b_nxt.hue_den = a_r.delta;
    b_nxt.hue_q   = '0;
    b_nxt.side    = a_r.side;
    vb_nxt        = va_r;
  end

  r2h_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vb_r),
    .in_ready  (div_in_ready),
    .in_st     (b_r),
    .out_valid (div_out_valid),
    .out_ready (rdy_f),
    .out_st    (div_out)
  );

  // stage F logic: signed term, sector offset, wrap into one turn.
  // Grey and black pixels divide by zero in the divider; their hue is forced to 0.
  always_comb begin
    logic signed [HS_W-1:0] term;
    logic signed [HS_W-1:0] base;
    logic signed [HS_W-1:0] hsum;
    term = $signed(HS_W'(div_out.hue_q));
    if (div_out.side.neg) term = -term;
    case (div_out.side.sector)
      r2h_pkg::SEC_RED:   base = '0;
      r2h_pkg::SEC_GREEN: base = HS_W'(2 * r2h_pkg::HUE_SECTOR);
      r2h_pkg::SEC_BLUE:  base = HS_W'(4 * r2h_pkg::HUE_SECTOR);
      default:            base = '0;
    endcase
    hsum = base + term;
    if (hsum < 0) hsum = hsum + HS_W'(r2h_pkg::HUE_FULL);
    if (div_out.side.grey || !div_out.side.defined) begin
      hue_nxt = '0;
    end else begin
      hue_nxt = hsum[r2h_pkg::HUE_W-1:0];
    end
    def_nxt = div_out.side.defined;
    sat_nxt = div_out.side.defined ? div_out.sat_q[CB-1:0] : '0;
    val_nxt = div_out.side.mx;
    vf_nxt  = div_out_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vf_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= va_nxt;
      if (rdy_b) vb_r <= vb_nxt;
      if (rdy_f) vf_r <= vf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) a_r <= a_nxt;
    if (rdy_b) b_r <= b_nxt;
    if (rdy_f) begin
      hue_r <= hue_nxt;
      def_r <= def_nxt;
      sat_r <= sat_nxt;
      val_r <= val_nxt;
    end
  end

  assign out_ch.valid       = vf_r;
  assign out_ch.hue         = hue_r;
  assign out_ch.hue_defined = def_r;
  assign out_ch.saturation  = sat_r;
  assign out_ch.brightness  = val_r;

  // ------------------------------------------------------------ assertions
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.hue < r2h_pkg::HUE_W'(r2h_pkg::HUE_FULL))
    else $error("hue outside one turn");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.hue_defined |->
      out_ch.hue == '0 && out_ch.saturation == '0 && out_ch.brightness == '0)
    else $error("black pixel with non-zero result");

  a_sat_le_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturation != '0 |-> out_ch.brightness != '0)
    else $error("saturation without brightness");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output stage");

endmodule

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef r2h_pkg::chan_t chan_t;

  // One HSV result as it leaves the converter
  typedef struct packed {
    logic [r2h_pkg::HUE_W-1:0] hue;
    logic                      hue_defined;
    chan_t                     saturation;
    chan_t                     brightness;
  } hsv_t;

  // Pipeline depth as the top-level header lists its stages: max/min, products,
  // one stage per divider bit, offset/wrap
  localparam int PIPE_DEPTH  = r2h_pkg::NDIV + 3;
  // Far beyond ~650 requests with both sides stalling about a third of the time
  localparam int CYCLE_LIMIT = 200000;
  // Percentage of cycles in which either side idles while gaps are enabled
  localparam int IDLE_PCT    = 36;

  logic clk = 1'b0;
  logic rst_n;

  r2h_pix_if pix ();
  r2h_hsv_if hsv ();

  rgb_to_hsv_converter_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix),
    .out_ch (hsv)
  );

  // Expected HSV results, oldest first
  hsv_t hsv_expected_q[$];
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  // Random idling on both channels; cleared for the back-to-back stretch
  bit   gaps_on        = 1'b1;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Integer HSV conversion. Hue is in 1/64 degree; sector chosen by the
  // channel holding the maximum, red before green before blue on a tie.
  // The sector term truncates toward zero, which SV's signed divide does.
  function automatic hsv_t predict_hsv(chan_t r, chan_t g, chan_t b);
    chan_t      mx;
    chan_t      mn;
    int         delta;
    int         diff;
    int         offset;
    int         hue_acc;
    logic [1:0] sector;
    hsv_t       res;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta   = int'(mx) - int'(mn);
    hue_acc = 0;
    res.brightness  = mx;
    res.hue_defined = (mx != '0);
    res.saturation  = '0;
    if (mx != '0) begin
      res.saturation = chan_t'((delta * r2h_pkg::CH_MAX) / int'(mx));
      // grey pixel: hue stays 0
      if (delta != 0) begin
        if (r == mx)      sector = r2h_pkg::SEC_RED;
        else if (g == mx) sector = r2h_pkg::SEC_GREEN;
        else              sector = r2h_pkg::SEC_BLUE;
        case (sector)
          r2h_pkg::SEC_RED: begin
            diff   = int'(g) - int'(b);
            offset = 0;
          end
          r2h_pkg::SEC_GREEN: begin
            diff   = int'(b) - int'(r);
            offset = 2 * r2h_pkg::HUE_SECTOR;
          end
          default: begin
            diff   = int'(r) - int'(g);
            offset = 4 * r2h_pkg::HUE_SECTOR;
          end
        endcase
        hue_acc = offset + (r2h_pkg::HUE_SECTOR * diff) / delta;
        // red sector with blue above green wraps round the circle
        if (hue_acc < 0) hue_acc += r2h_pkg::HUE_FULL;
      end
    end
    res.hue = hue_acc[r2h_pkg::HUE_W-1:0];
    return res;
  endfunction

  // Present one pixel request and hold it until accepted. The expectation is
  // queued first: order is preserved, so it always precedes its result.
  // valid is left high on return; the next call or drain_results decides.
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
    hsv_expected_q.push_back(predict_hsv(r, g, b));
    if (gaps_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        pix.valid <= 1'b0;
        @(posedge clk);
      end
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    // ready read just after the edge still shows its pre-edge value
    do @(posedge clk); while (!pix.ready);
  endtask

  // Sender holds off until the pipeline has handed back everything
  task automatic drain_results();
    pix.valid <= 1'b0;
    while (hsv_expected_q.size() != 0) @(posedge clk);
  endtask

  // Extremes, ties, grey, black and the hue wrap, one request each
  task automatic test_corner_pixels();
    send_pixel(8'd0,   8'd0,   8'd0);     // black: hue undefined
    send_pixel(8'd255, 8'd255, 8'd255);   // white
    send_pixel(8'd1,   8'd1,   8'd1);     // dimmest grey
    send_pixel(8'd128, 8'd128, 8'd128);   // mid grey
    send_pixel(8'd255, 8'd0,   8'd0);     // pure red
    send_pixel(8'd0,   8'd255, 8'd0);     // pure green
    send_pixel(8'd0,   8'd0,   8'd255);   // pure blue
    send_pixel(8'd200, 8'd200, 8'd10);    // red/green tie, red wins
    send_pixel(8'd10,  8'd200, 8'd200);   // green/blue tie, green wins
    send_pixel(8'd200, 8'd10,  8'd200);   // red/blue tie, wraps negative
    send_pixel(8'd255, 8'd0,   8'd255);   // magenta
    send_pixel(8'd255, 8'd0,   8'd1);     // just below 360 degrees
    send_pixel(8'd255, 8'd0,   8'd254);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd0);     // top of red sector
    send_pixel(8'd0,   8'd255, 8'd254);   // top of green sector
    send_pixel(8'd254, 8'd0,   8'd255);   // top of blue sector
    send_pixel(8'd1,   8'd0,   8'd1);
    send_pixel(8'd255, 8'd255, 8'd254);   // smallest delta at full scale
    send_pixel(8'd2,   8'd1,   8'd0);
  endtask

  // Uniform random pixels with idling on both sides
  task automatic test_random_pixels(input int n);
    repeat (n) send_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
  endtask

  // Long stretch at full rate: no gaps from the sender, ready held high
  task automatic test_back_to_back(input int n);
    gaps_on = 1'b0;
    repeat (n) send_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
    gaps_on = 1'b1;
  endtask

  // Random pixels biased towards the awkward corners of the conversion
  task automatic test_shaped_pixels(input int n);
    chan_t c [3];
    chan_t hi;
    chan_t lo;
    int    k;
    repeat (n) begin
      foreach (c[i]) c[i] = chan_t'($urandom);
      hi = chan_t'($urandom);
      k  = $urandom_range(2);
      case ($urandom_range(5))
        0: begin                              // grey, black now and then
          if ($urandom_range(7) == 0) hi = '0;
          foreach (c[i]) c[i] = hi;
        end
        1: begin                              // two channels tie for max
          c[k] = hi;
          c[(k + 1) % 3] = hi;
          c[(k + 2) % 3] = chan_t'($urandom_range(hi));
        end
        2: begin                              // full-scale and zero channels
          c[k] = 8'd255;
          c[(k + 1) % 3] = '0;
        end
        3: begin                              // values next to the rails
          foreach (c[i]) begin
            case ($urandom_range(3))
              0: c[i] = 8'd0;
              1: c[i] = 8'd1;
              2: c[i] = 8'd254;
              default: c[i] = 8'd255;
            endcase
          end
        end
        4: ;                                  // plain random
        default: begin                        // tiny delta, large quotients
          lo = (hi > 8'd2) ? hi - chan_t'($urandom_range(2)) : hi;
          foreach (c[i]) c[i] = chan_t'($urandom_range(hi, lo));
        end
      endcase
      send_pixel(c[0], c[1], c[2]);
    end
  endtask

  // Result side: check each accepted result against the oldest expectation,
  // then pick next cycle's ready
  always @(posedge clk) begin : result_check
    hsv_t got;
    hsv_t want;
    if (rst_n && hsv.valid && hsv.ready) begin
      got = '{hsv.hue, hsv.hue_defined, hsv.saturation, hsv.brightness};
      if (hsv_expected_q.size() == 0) begin
        mismatch_count++;
        $display("%t unexpected result: hue=%0d def=%0d sat=%0d val=%0d",
                 $realtime, got.hue, got.hue_defined, got.saturation, got.brightness);
      end else begin
        want = hsv_expected_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          $display("%t mismatch: expected hue=%0d def=%0d sat=%0d val=%0d,",
                   $realtime, want.hue, want.hue_defined, want.saturation,
                   want.brightness);
          $display("%t          got hue=%0d def=%0d sat=%0d val=%0d",
                   $realtime, got.hue, got.hue_defined, got.saturation,
                   got.brightness);
        end
      end
    end
    hsv.ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    pix.valid <= 1'b0;
    pix.red   <= '0;
    pix.green <= '0;
    pix.blue  <= '0;
    rst_n     <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_pixels();
    drain_results();
    test_random_pixels(220);
    test_back_to_back(150);
    drain_results();
    test_shaped_pixels(260);
    drain_results();

    // let any stray extra result surface
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
